@@ sv/rae_pkg.sv @@
// shared types, constants and flag functions of the register alu instruction executor
package rae_pkg;

  localparam int StackDepth = 16;
  localparam int LevelW     = $clog2(StackDepth + 1);
  localparam int StkAw      = $clog2(StackDepth);
  localparam int NumRegs    = 32;
  localparam int RegAw      = 5;
  localparam int WordW      = 32;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_AND  = 5'd2,
    OP_XOR  = 5'd3,
    OP_OR   = 5'd4,
    OP_ADDI = 5'd5,
    OP_SUBI = 5'd6,
    OP_ANDI = 5'd7,
    OP_XORI = 5'd8,
    OP_ORI  = 5'd9,
    OP_MOVR = 5'd10,
    OP_MOVI = 5'd11,
    OP_SWAP = 5'd12,
    OP_MUL  = 5'd13,
    OP_DIV  = 5'd14,
    OP_SKIE = 5'd15,
    OP_MULL = 5'd16,
    OP_PUSH = 5'd17,
    OP_POP  = 5'd18,
    OP_IN   = 5'd19,
    OP_OUT  = 5'd20,
    OP_CLR  = 5'd21
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2,
    ERR_DIV0  = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDS,
    ST_RDO,
    ST_RDD,
    ST_EXEC,
    ST_WR2,
    ST_MULW,
    ST_SHIFT,
    ST_DIV,
    ST_DIVQ,
    ST_DIVR,
    ST_POPW,
    ST_CLR,
    ST_FIN
  } state_e;

  localparam int FlagParity = 0;
  localparam int FlagZero   = 1;
  localparam int FlagSign   = 2;
  localparam int FlagOvf    = 5;

  // parity, zero and sign from a written value
  function automatic logic [7:0] status_flags(input logic [7:0] f, input logic [WordW-1:0] r);
    logic [7:0] n;
    n = f;
    n[FlagZero]   = (r == '0);
    n[FlagSign]   = r[WordW-1];
    n[FlagParity] = (r != '0) && !r[WordW-1] && (^r);
    return n;
  endfunction

  // overflow from operand sign classes, left alone when an operand is zero
  function automatic logic [7:0] ovf_flags(input logic [7:0] f, input logic a_pos,
                                           input logic a_neg, input logic b_pos,
                                           input logic b_neg, input logic [WordW-1:0] r);
    logic [7:0] n;
    logic       r_pos;
    n     = f;
    r_pos = (r != '0) && !r[WordW-1];
    if (a_pos && b_pos) begin
      n[FlagOvf] = !r_pos;
    end else if (a_neg && b_neg) begin
      n[FlagOvf] = !r[WordW-1];
    end else if ((a_pos || a_neg) && (b_pos || b_neg)) begin
      n[FlagOvf] = 1'b0;
    end
    return n;
  endfunction

endpackage

@@ sv/rae_div.sv @@
// iterative unsigned divider, one quotient bit per cycle
module rae_div
  import rae_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] dvd_i,
  input  logic [WordW-1:0] dvs_i,
  output logic             done_o,
  output logic [WordW-1:0] quo_o,
  output logic [WordW-1:0] rem_o
);

  logic               busy_q;
  logic               done_q;
  logic [RegAw-1:0]   cnt_q;
  logic [WordW-1:0]   quo_q;
  logic [WordW-1:0]   rem_q;
  logic [WordW-1:0]   dvs_q;
  logic [WordW:0]     shifted;
  logic [WordW:0]     diff;

  assign shifted = {rem_q, quo_q[WordW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == RegAw'(WordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dvd_i;
      rem_q <= '0;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      if (!diff[WordW]) begin
        rem_q <= diff[WordW-1:0];
        quo_q <= {quo_q[WordW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[WordW-1:0];
        quo_q <= {quo_q[WordW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/register_alu_instruction_executor.sv @@
// top level: sequencer, register file, stack and shared datapath of the executor
// One instruction is taken at a time and gives one result beat. Register operands are read
// one per cycle through the single read port of the register file. Swap, mul and pop add a
// second write or wait state; mull is lengthened by the one-bit-a-cycle search for the leading
// one of the product; div by the 32-step divider; clear by zeroing each word on the stack in
// turn. A new instruction is taken while the previous result still waits on the output.
module register_alu_instruction_executor
  import rae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // func, dest_index, source_index, other_index, immediate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // flag_bits, skip_next, read_value, error_code
);

  state_e state_q, state_d;

  logic [WordW-1:0]   rf_q [NumRegs];
  logic [NumRegs-1:0] vld_q;
  logic [WordW-1:0]   rdata_q;
  logic               rvld_q;
  logic [WordW-1:0]   rval;
  logic               rf_we;
  logic [RegAw-1:0]   rf_waddr;
  logic [WordW-1:0]   rf_wdata;
  logic [RegAw-1:0]   rf_raddr;
  logic               rf_clr;

  logic [WordW-1:0]   stk_q [StackDepth];
  logic [WordW-1:0]   stk_rdata_q;
  logic               stk_we;
  logic [StkAw-1:0]   stk_waddr;
  logic [WordW-1:0]   stk_wdata;
  logic [StkAw-1:0]   stk_raddr;
  logic [LevelW-1:0]  level_q, level_d;
  logic [LevelW-1:0]  cnt_q, cnt_d;

  logic [4:0]         op_q;
  logic [RegAw-1:0]   d_q, s_q, o_q;
  logic [WordW-1:0]   imm_q, ra_q, rb_q, w_q, prod_q;
  logic [WordW-1:0]   opb, alu_res, mul_a, mul_b;
  logic [7:0]         flags_q;
  logic               skip_q;
  logic [WordW-1:0]   readv_q;
  err_e               err_q;
  logic               negq_q, negr_q;
  logic               accept;
  logic               out_load;
  logic [47:0]        out_q;
  logic               out_vld_q;

  logic               div_start, div_done;
  logic [WordW-1:0]   div_quo, div_rem, quo_s, rem_s;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign rval          = rvld_q ? rdata_q : '0;
  assign opb           = (op_q <= OP_OR) ? rb_q : imm_q;
  assign mul_a         = (op_q == OP_MULL) ? rval : ra_q;
  assign mul_b         = (op_q == OP_MULL) ? ra_q : rb_q;
  assign quo_s         = negq_q ? (WordW'(0) - div_quo) : div_quo;
  assign rem_s         = negr_q ? (WordW'(0) - div_rem) : div_rem;

  always_comb begin
    case (op_q)
      OP_ADD, OP_ADDI: alu_res = ra_q + opb;
      OP_SUB, OP_SUBI: alu_res = ra_q - opb;
      OP_AND, OP_ANDI: alu_res = ra_q & opb;
      OP_XOR, OP_XORI: alu_res = ra_q ^ opb;
      default:         alu_res = ra_q | opb;
    endcase
  end

  rae_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (rval[WordW-1] ? (WordW'(0) - rval) : rval),
    .dvs_i   (ra_q[WordW-1] ? (WordW'(0) - ra_q) : ra_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    rf_we     = 1'b0;
    rf_waddr  = d_q;
    rf_wdata  = alu_res;
    rf_raddr  = s_q;
    rf_clr    = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = level_q[StkAw-1:0];
    stk_wdata = rval;
    stk_raddr = level_q[StkAw-1:0];
    level_d   = level_q;
    cnt_d     = cnt_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_RDS;
      end
      ST_RDS: begin
        rf_raddr = s_q;
        state_d  = ST_RDO;
      end
      ST_RDO: begin
        rf_raddr = o_q;
        state_d  = ST_RDD;
      end
      ST_RDD: begin
        rf_raddr = (op_q == OP_OUT) ? RegAw'(0) : d_q;
        state_d  = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_FIN;
        case (op_q)
          OP_ADD, OP_SUB, OP_AND, OP_XOR, OP_OR,
          OP_ADDI, OP_SUBI, OP_ANDI, OP_XORI, OP_ORI: begin
            rf_we = 1'b1;
          end
          OP_MOVR: begin
            rf_we    = 1'b1;
            rf_wdata = ra_q;
          end
          OP_MOVI: begin
            rf_we    = 1'b1;
            rf_wdata = imm_q;
          end
          OP_SWAP: begin
            rf_we    = 1'b1;
            rf_wdata = ra_q;
            state_d  = ST_WR2;
          end
          OP_MUL, OP_MULL: state_d = ST_MULW;
          OP_DIV: begin
            if (ra_q != '0) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
          OP_PUSH: begin
            if (level_q < LevelW'(StackDepth)) begin
              stk_we  = 1'b1;
              level_d = level_q + 1'b1;
            end
          end
          OP_POP: begin
            if (level_q != '0) begin
              level_d   = level_q - 1'b1;
              stk_raddr = level_d[StkAw-1:0];
              state_d   = ST_POPW;
            end
          end
          OP_IN: begin
            rf_we    = 1'b1;
            rf_waddr = RegAw'(0);
            rf_wdata = imm_q;
          end
          OP_CLR: begin
            rf_clr  = 1'b1;
            cnt_d   = '0;
            state_d = ST_CLR;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_WR2: begin
        rf_we    = 1'b1;
        rf_waddr = s_q;
        rf_wdata = w_q;
        state_d  = ST_FIN;
      end
      ST_MULW: begin
        rf_we = 1'b1;
        if (op_q == OP_MULL) begin
          rf_waddr = s_q;
          rf_wdata = {{(WordW-4){1'b0}}, prod_q[3:0]};
          state_d  = ST_SHIFT;
        end else begin
          rf_wdata = prod_q;
          state_d  = ST_FIN;
        end
      end
      ST_SHIFT: begin
        if (prod_q[WordW-1] || (w_q[WordW-1:4] == '0)) begin
          rf_we    = 1'b1;
          rf_wdata = prod_q[WordW-1] ? {{(WordW-4){1'b0}}, prod_q[3:0]} : w_q;
          state_d  = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DIVQ;
      end
      ST_DIVQ: begin
        rf_we    = 1'b1;
        rf_wdata = quo_s;
        state_d  = ST_DIVR;
      end
      ST_DIVR: begin
        rf_we    = 1'b1;
        rf_waddr = s_q;
        rf_wdata = rem_s;
        state_d  = ST_FIN;
      end
      ST_POPW: begin
        rf_we    = 1'b1;
        rf_wdata = stk_rdata_q;
        state_d  = ST_FIN;
      end
      ST_CLR: begin
        if (cnt_q < level_q) begin
          stk_we    = 1'b1;
          stk_waddr = cnt_q[StkAw-1:0];
          stk_wdata = '0;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // register file and stack storage
  always_ff @(posedge clk_i) begin
    if (rf_we) rf_q[rf_waddr] <= rf_wdata;
    rdata_q <= rf_q[rf_raddr];
    if (stk_we) stk_q[stk_waddr] <= stk_wdata;
    stk_rdata_q <= stk_q[stk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rvld_q    <= 1'b0;
      level_q   <= '0;
      cnt_q     <= '0;
      flags_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rvld_q  <= vld_q[rf_raddr];
      if (rf_clr) begin
        vld_q <= '0;
      end else if (rf_we) begin
        vld_q[rf_waddr] <= 1'b1;
      end
      level_q <= level_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_EXEC: begin
          case (op_q)
            OP_ADD, OP_ADDI: begin
              flags_q <= ovf_flags(status_flags(flags_q, alu_res),
                                   (ra_q != '0) && !ra_q[WordW-1], ra_q[WordW-1],
                                   (opb != '0) && !opb[WordW-1], opb[WordW-1], alu_res);
            end
            OP_SUB, OP_SUBI: begin
              flags_q <= ovf_flags(status_flags(flags_q, alu_res),
                                   (ra_q != '0) && !ra_q[WordW-1], ra_q[WordW-1],
                                   opb[WordW-1], (opb != '0) && !opb[WordW-1], alu_res);
            end
            OP_AND, OP_XOR, OP_OR, OP_ANDI, OP_XORI, OP_ORI: begin
              flags_q <= status_flags(flags_q, alu_res);
            end
            OP_IN: flags_q <= status_flags(flags_q, imm_q);
            default: flags_q <= flags_q;
          endcase
        end
        ST_MULW: begin
          if (op_q == OP_MULL) begin
            flags_q <= status_flags(flags_q, prod_q);
          end else begin
            flags_q <= ovf_flags(status_flags(flags_q, prod_q),
                                 (ra_q != '0) && !ra_q[WordW-1], ra_q[WordW-1],
                                 (rb_q != '0) && !rb_q[WordW-1], rb_q[WordW-1], prod_q);
          end
        end
        ST_DIVR: flags_q <= status_flags(flags_q, (d_q == s_q) ? rem_s : quo_s);
        default: flags_q <= flags_q;
      endcase
    end
  end

  // operand and result datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tdata[4:0];
      d_q     <= s_axis_tdata[9:5];
      s_q     <= s_axis_tdata[14:10];
      o_q     <= s_axis_tdata[19:15];
      imm_q   <= s_axis_tdata[51:20];
      skip_q  <= 1'b0;
      readv_q <= '0;
      err_q   <= ERR_OK;
    end
    case (state_q)
      ST_RDO: ra_q <= rval;
      ST_RDD: rb_q <= rval;
      ST_EXEC: begin
        w_q    <= rval;
        prod_q <= mul_a * mul_b;
        negq_q <= rval[WordW-1] ^ ra_q[WordW-1];
        negr_q <= rval[WordW-1];
        case (op_q)
          OP_DIV:  if (ra_q == '0) err_q <= ERR_DIV0;
          OP_SKIE: skip_q <= (rval == ra_q);
          OP_PUSH: if (level_q >= LevelW'(StackDepth)) err_q <= ERR_FULL;
          OP_POP:  if (level_q == '0) err_q <= ERR_EMPTY;
          OP_OUT:  readv_q <= rval;
          default: skip_q <= skip_q;
        endcase
      end
      ST_MULW:  w_q <= prod_q;
      ST_SHIFT: w_q <= w_q >> 1;
      default:  w_q <= w_q;
    endcase
    if (out_load) begin
      out_q <= {5'd0, err_q, readv_q, skip_q, flags_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
